// ===== hdl/mtca_pkg.sv =====
package mtca_pkg;

    localparam int ROW_BITS       = 64;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int WIDTH_BITS     = 7;
    localparam int THR_BITS       = 4;
    localparam int CNT_BITS       = 4;
    localparam int CFG_ADDR_BITS  = 1;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ROW_WIDTH      = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LIVE_THRESHOLD = 1'b1;

    localparam logic [WIDTH_BITS-1:0] RST_ROW_WIDTH = 7'd64;
    localparam logic [WIDTH_BITS-1:0] MIN_WIDTH     = 7'd3;
    localparam logic [THR_BITS-1:0]   RST_THRESHOLD = 4'd7;

    // grid progress
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    localparam int Q_DEPTH    = 3;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 2;

    typedef struct packed {
        logic up;
        logic mid;
        logic down;
    } t_col;

    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                last;
    } t_res;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

// ===== hdl/mtca_ifs.sv =====
interface mtca_row_if import mtca_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] row_cells;
    logic                final_row;

    modport source (output valid, output row_cells, output final_row, input ready);
    modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

interface mtca_res_if import mtca_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] next_row_cells;
    logic                final_out;

    modport source (output valid, output next_row_cells, output final_out, input ready);
    modport sink   (input valid, input next_row_cells, input final_out, output ready);
endinterface

interface mtca_cfg_if import mtca_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hdl/mtca_cell.sv =====
module mtca_cell import mtca_pkg::*; #(
    parameter int COL_IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic                  i_row_bit,
    input  logic [WIDTH_BITS-1:0] i_width,
    input  logic [THR_BITS-1:0]   i_thresh,
    input  t_col                  i_left,
    input  t_col                  i_right,
    output t_col                  o_col,
    output logic                  o_next
);

    localparam logic [WIDTH_BITS-1:0] COL = WIDTH_BITS'(COL_IDX);

    logic                r_up;
    logic                r_mid;
    logic                w_act;
    logic                w_border;
    logic [CNT_BITS-1:0] w_cnt;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_up  <= r_mid;
            r_mid <= i_row_bit;
        end
    end

    assign w_act    = (COL < i_width);
    assign w_border = (COL == '0) || (COL == i_width - 7'd1);

    assign o_col.up   = r_up & w_act;
    assign o_col.mid  = r_mid & w_act;
    assign o_col.down = i_row_bit;

    assign w_cnt = CNT_BITS'(i_left.up)  + CNT_BITS'(i_left.mid)  + CNT_BITS'(i_left.down)
                 + CNT_BITS'(o_col.up)   + CNT_BITS'(o_col.mid)   + CNT_BITS'(o_col.down)
                 + CNT_BITS'(i_right.up) + CNT_BITS'(i_right.mid) + CNT_BITS'(i_right.down);

    always_comb begin
        if (!w_act) begin
            o_next = 1'b0;
        end else if (w_border) begin
            o_next = o_col.mid;
        end else begin
            o_next = (w_cnt >= i_thresh);
        end
    end

endmodule

// ===== hdl/mtca_outq.sv =====
module mtca_outq import mtca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    input  t_res              i_res0,
    input  t_res              i_res1,
    output logic              o_room,
    mtca_res_if.source        o_res
);

    t_res                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr;
    logic [Q_PTR_BITS-1:0] r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic [Q_PTR_BITS-1:0] w_wr1;
    logic                  w_pop;

    function automatic logic [Q_PTR_BITS-1:0] ptr_next(input logic [Q_PTR_BITS-1:0] p);
        logic [Q_PTR_BITS-1:0] q;
        q = (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    assign w_wr1 = ptr_next(r_wr);
    assign w_pop = o_res.valid & o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.second) begin
            r_mem[w_wr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.second) begin
                r_wr <= ptr_next(w_wr1);
            end else if (i_push.first) begin
                r_wr <= w_wr1;
            end
            if (w_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            r_cnt <= r_cnt + Q_CNT_BITS'(i_push.first) + Q_CNT_BITS'(i_push.second)
                   - Q_CNT_BITS'(w_pop);
        end
    end

    assign o_room               = (r_cnt <= Q_CNT_BITS'(1));
    assign o_res.valid          = (r_cnt != '0);
    assign o_res.next_row_cells = r_mem[r_rd].cells;
    assign o_res.final_out      = r_mem[r_rd].last;

endmodule

// ===== hdl/moore_threshold_ca_generation.sv =====
// channel  | dir | payload                      | handshake
// i_rows   | in  | row_cells[63:0], final_row   | valid/ready
// o_next   | out | next_row_cells[63:0], final_out | valid/ready
// i_cfg    | in  | addr (0 width, 1 threshold), data[6:0] | valid/ready, ready always high
//
// One row request per cycle while i_rows.ready is high; results go to a 3-entry
// output queue, which o_next reads out in order. A final row with rows held
// yields two results, pushed into the queue together.
// Each column cell counts its 3x3 neighborhood in the accept cycle.
// i_rows.ready drops when the queue holds two or more results.
// Synchronous reset clears control and sets width 64, threshold 7.
module moore_threshold_ca_generation import mtca_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtca_row_if.sink   i_rows,
    mtca_res_if.source o_next,
    mtca_cfg_if.sink   i_cfg
);

    logic [WIDTH_BITS-1:0] r_row_width;
    logic [THR_BITS-1:0]   r_thresh;
    logic [1:0]            r_held;
    logic [1:0]            n_held;

    logic [WIDTH_BITS-1:0] w_width;
    logic [ROW_BITS-1:0]   w_row;
    logic [ROW_BITS-1:0]   w_gen;
    logic [ROW_BITS-1:0]   w_mid_row;
    t_col                  w_col [MAX_WIDTH];
    logic                  w_acc;
    logic                  w_room;
    t_push                 w_push;
    t_res                  w_res0;
    t_res                  w_res1;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RST_ROW_WIDTH;
            r_thresh    <= RST_THRESHOLD;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_ROW_WIDTH: begin
                    r_row_width <= i_cfg.data;
                end
                REG_LIVE_THRESHOLD: begin
                    r_thresh <= i_cfg.data[THR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_row_width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_width = WIDTH_BITS'(MAX_WIDTH);
        end else if (r_row_width < MIN_WIDTH) begin
            w_width = MIN_WIDTH;
        end else begin
            w_width = r_row_width;
        end
    end

    always_comb begin
        for (int j = 0; j < ROW_BITS; j++) begin
            w_row[j] = i_rows.row_cells[j] & (WIDTH_BITS'(j) < w_width);
        end
    end

    assign w_acc = i_rows.valid & i_rows.ready;

    genvar c;
    generate
        for (c = 0; c < MAX_WIDTH; c++) begin : g_cell
            t_col w_l;
            t_col w_r;
            if (c == 0) begin : g_l0
                assign w_l = '0;
            end else begin : g_l
                assign w_l = w_col[c-1];
            end
            if (c == MAX_WIDTH - 1) begin : g_r0
                assign w_r = '0;
            end else begin : g_r
                assign w_r = w_col[c+1];
            end
            mtca_cell #(.COL_IDX(c)) u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_acc),
                .i_row_bit (w_row[c]),
                .i_width   (w_width),
                .i_thresh  (r_thresh),
                .i_left    (w_l),
                .i_right   (w_r),
                .o_col     (w_col[c]),
                .o_next    (w_gen[c])
            );
            assign w_mid_row[c] = w_col[c].mid;
        end
        if (MAX_WIDTH < ROW_BITS) begin : g_hi
            assign w_gen[ROW_BITS-1:MAX_WIDTH]     = '0;
            assign w_mid_row[ROW_BITS-1:MAX_WIDTH] = '0;
        end
    endgenerate

    always_comb begin
        w_res1.cells = w_row;
        w_res1.last  = 1'b1;
        case (r_held)
            HELD_NONE: begin
                w_res0.cells = w_row;
                w_res0.last  = 1'b1;
            end
            HELD_ONE: begin
                w_res0.cells = w_mid_row;
                w_res0.last  = 1'b0;
            end
            default: begin
                w_res0.cells = w_gen;
                w_res0.last  = 1'b0;
            end
        endcase
    end

    assign w_push.first  = w_acc & ((r_held != HELD_NONE) | i_rows.final_row);
    assign w_push.second = w_acc & (r_held != HELD_NONE) & i_rows.final_row;

    always_comb begin
        n_held = r_held;
        if (w_acc) begin
            if (i_rows.final_row) begin
                n_held = HELD_NONE;
            end else if (r_held == HELD_NONE) begin
                n_held = HELD_ONE;
            end else begin
                n_held = HELD_TWO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= HELD_NONE;
        end else begin
            r_held <= n_held;
        end
    end

    mtca_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .o_room  (w_room),
        .o_res   (o_next)
    );

    assign i_rows.ready = w_room;

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_rows.final_row |=> r_held == HELD_NONE)
        else $error("grid did not restart after final row");

    a_held_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held == HELD_NONE || r_held == HELD_ONE || r_held == HELD_TWO)
        else $error("row progress out of range");

    a_final_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_rows.final_row |=> o_next.valid)
        else $error("final row produced no result");

    a_second_implies_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.second |-> w_push.first && w_room)
        else $error("second result pushed without first");

endmodule
